>>> rtl/q6ge_pkg.sv
// Package with command codes, status codes, coefficient tables and shared types.
package q6ge_pkg;

  localparam int unsigned IoWidth   = 18;
  localparam int unsigned CoefShift = 24;
  localparam int unsigned CoefWidth = 25;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_DFT   = 2'd2,
    CMD_PHASE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BAD_QUDIT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_ACC   = 2'd1,
    SRC_GROUP = 2'd2
  } wr_src_e;

  typedef logic signed [CoefWidth-1:0] coef_t;

  function automatic coef_t dft_re(input logic [2:0] p);
    case (p)
      3'd0: dft_re = 25'sd6849270;
      3'd1: dft_re = 25'sd3424635;
      3'd2: dft_re = -25'sd3424635;
      3'd3: dft_re = -25'sd6849270;
      3'd4: dft_re = -25'sd3424635;
      3'd5: dft_re = 25'sd3424635;
      default: dft_re = '0;
    endcase
  endfunction

  function automatic coef_t dft_im(input logic [2:0] p);
    case (p)
      3'd1, 3'd2: dft_im = 25'sd5931642;
      3'd4, 3'd5: dft_im = -25'sd5931642;
      default: dft_im = '0;
    endcase
  endfunction

  function automatic coef_t ph_re(input logic [2:0] p);
    case (p)
      3'd0: ph_re = 25'sd16777216;
      3'd1: ph_re = 25'sd8388608;
      3'd2: ph_re = -25'sd8388608;
      3'd3: ph_re = -25'sd16777216;
      3'd4: ph_re = -25'sd8388608;
      3'd5: ph_re = 25'sd8388608;
      default: ph_re = '0;
    endcase
  endfunction

  function automatic coef_t ph_im(input logic [2:0] p);
    case (p)
      3'd1, 3'd2: ph_im = 25'sd14529495;
      3'd4, 3'd5: ph_im = -25'sd14529495;
      default: ph_im = '0;
    endcase
  endfunction

  // Product of two digits modulo six.
  function automatic logic [2:0] mul6(input logic [2:0] a, input logic [2:0] b);
    logic [5:0] m;
    m = a * b;
    case (m)
      6'd0, 6'd6, 6'd12, 6'd18, 6'd24: mul6 = 3'd0;
      6'd1, 6'd25: mul6 = 3'd1;
      6'd2, 6'd8, 6'd20: mul6 = 3'd2;
      6'd3, 6'd9, 6'd15: mul6 = 3'd3;
      6'd4, 6'd10, 6'd16: mul6 = 3'd4;
      6'd5: mul6 = 3'd5;
      default: mul6 = 3'd0;
    endcase
  endfunction

  typedef struct packed {
    logic       mem_rd;
    logic       mem_wr;
    wr_src_e    wr_src;
    logic       grp_load;
    logic       acc_clr;
    logic       acc_en;
    logic       res_load;
    logic       res_read;
  } cmd_t;

endpackage

>>> rtl/q6ge_datapath.sv
// Datapath: amplitude memories, group registers, complex multiply-accumulate.
module q6ge_datapath #(
  parameter int unsigned MaxQudits = 4,
  parameter int unsigned AmpWidth  = 18,
  parameter int unsigned AddrW     = 11
) (
  input  logic                              clk_i,
  input  q6ge_pkg::cmd_t                    cmd_i,
  input  logic [AddrW-1:0]                  addr_i,
  input  logic [2:0]                        slot_i,
  input  logic [2:0]                        coef_sel_i,
  input  logic                              use_phase_i,
  input  logic signed [q6ge_pkg::IoWidth-1:0] wr_re_i,
  input  logic signed [q6ge_pkg::IoWidth-1:0] wr_im_i,
  output logic signed [q6ge_pkg::IoWidth-1:0] rd_re_o,
  output logic signed [q6ge_pkg::IoWidth-1:0] rd_im_o
);
  import q6ge_pkg::*;

  localparam int unsigned Depth = 6 ** MaxQudits;
  localparam int unsigned AccW  = AmpWidth + CoefWidth + 5;
  localparam int unsigned PrdW  = AmpWidth + CoefWidth;

  logic signed [AmpWidth-1:0] mem_re [Depth];
  logic signed [AmpWidth-1:0] mem_im [Depth];
  logic signed [AmpWidth-1:0] rdat_re_q, rdat_im_q;
  logic signed [AmpWidth-1:0] grp_re_q [6];
  logic signed [AmpWidth-1:0] grp_im_q [6];
  logic signed [AccW-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [PrdW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [AmpWidth-1:0] op_re, op_im, wdat_re, wdat_im, sat_re, sat_im;
  logic signed [AmpWidth-1:0] res_re_q, res_im_q;
  coef_t c_re, c_im;

  function automatic logic signed [AmpWidth-1:0] sat_in(
      input logic signed [IoWidth-1:0] v);
    logic signed [AmpWidth-1:0] hi, lo;
    logic signed [IoWidth+AmpWidth-1:0] x;
    hi = {1'b0, {(AmpWidth-1){1'b1}}};
    lo = {1'b1, {(AmpWidth-1){1'b0}}};
    x = (IoWidth+AmpWidth)'(v);
    if (x > (IoWidth+AmpWidth)'(hi)) sat_in = hi;
    else if (x < (IoWidth+AmpWidth)'(lo)) sat_in = lo;
    else sat_in = AmpWidth'(x);
  endfunction

  function automatic logic signed [IoWidth-1:0] sat_out(
      input logic signed [AmpWidth-1:0] v);
    logic signed [IoWidth-1:0] hi, lo;
    logic signed [IoWidth+AmpWidth-1:0] x;
    hi = {1'b0, {(IoWidth-1){1'b1}}};
    lo = {1'b1, {(IoWidth-1){1'b0}}};
    x = (IoWidth+AmpWidth)'(v);
    if (x > (IoWidth+AmpWidth)'(hi)) sat_out = hi;
    else if (x < (IoWidth+AmpWidth)'(lo)) sat_out = lo;
    else sat_out = IoWidth'(x);
  endfunction

  function automatic logic signed [AmpWidth-1:0] round_sat(
      input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] h, q, hi, lo;
    h  = a + (AccW'(1) <<< (CoefShift - 1));
    q  = h >>> CoefShift;
    hi = AccW'((1 << (AmpWidth - 1)) - 1);
    lo = -hi - AccW'(1);
    if (q > hi) round_sat = hi[AmpWidth-1:0];
    else if (q < lo) round_sat = lo[AmpWidth-1:0];
    else round_sat = q[AmpWidth-1:0];
  endfunction

  assign c_re  = use_phase_i ? ph_re(coef_sel_i) : dft_re(coef_sel_i);
  assign c_im  = use_phase_i ? ph_im(coef_sel_i) : dft_im(coef_sel_i);
  assign op_re = use_phase_i ? rdat_re_q : grp_re_q[slot_i];
  assign op_im = use_phase_i ? rdat_im_q : grp_im_q[slot_i];
  assign p_rr  = PrdW'(c_re) * PrdW'(op_re);
  assign p_ii  = PrdW'(c_im) * PrdW'(op_im);
  assign p_ri  = PrdW'(c_re) * PrdW'(op_im);
  assign p_ir  = PrdW'(c_im) * PrdW'(op_re);

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (cmd_i.acc_clr) begin
      acc_re_d = '0;
      acc_im_d = '0;
    end
    if (cmd_i.acc_en) begin
      acc_re_d = acc_re_d + AccW'(p_rr) - AccW'(p_ii);
      acc_im_d = acc_im_d + AccW'(p_ri) + AccW'(p_ir);
    end
  end

  assign sat_re = round_sat(acc_re_q);
  assign sat_im = round_sat(acc_im_q);

  always_comb begin
    case (cmd_i.wr_src)
      SRC_ACC: begin
        wdat_re = sat_re;
        wdat_im = sat_im;
      end
      SRC_GROUP: begin
        wdat_re = rdat_re_q;
        wdat_im = rdat_im_q;
      end
      default: begin
        wdat_re = sat_in(wr_re_i);
        wdat_im = sat_in(wr_im_i);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_re[addr_i] <= wdat_re;
      mem_im[addr_i] <= wdat_im;
    end
    if (cmd_i.mem_rd) begin
      rdat_re_q <= mem_re[addr_i];
      rdat_im_q <= mem_im[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    if (cmd_i.grp_load) begin
      grp_re_q[slot_i] <= rdat_re_q;
      grp_im_q[slot_i] <= rdat_im_q;
    end
    if (cmd_i.res_load) begin
      res_re_q <= cmd_i.res_read ? rdat_re_q : '0;
      res_im_q <= cmd_i.res_read ? rdat_im_q : '0;
    end
  end

  assign rd_re_o = sat_out(res_re_q);
  assign rd_im_o = sat_out(res_im_q);

endmodule

>>> rtl/q6ge_controller.sv
// Controller: command decode, index walk and group sequencing.
module q6ge_controller #(
  parameter int unsigned MaxQudits = 4,
  parameter int unsigned AddrW     = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [10:0]          index_i,
  input  logic [1:0]           qa_i,
  input  logic [1:0]           qb_i,
  input  logic [2:0]           qcount_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output q6ge_pkg::cmd_t       dp_o,
  output logic [AddrW-1:0]     addr_o,
  output logic [2:0]           slot_o,
  output logic [2:0]           coef_sel_o,
  output logic                 use_phase_o
);
  import q6ge_pkg::*;

  localparam int unsigned Depth = 6 ** MaxQudits;
  localparam int unsigned QW    = $clog2(MaxQudits + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDRES = 9'b000000010,
    S_GRD   = 9'b000000100,
    S_GLD   = 9'b000001000,
    S_MAC   = 9'b000010000,
    S_GWR   = 9'b000100000,
    S_PRD   = 9'b001000000,
    S_PMAC  = 9'b010000000,
    S_PWR   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW:0] dim, i_q, i_d, base_q, base_d, stride_q, stride_d, low_q, low_d;
  logic [2:0] k_q, k_d, j_q, j_d, da, db;
  logic [2:0] dig_q [MaxQudits];
  logic [2:0] dig_d [MaxQudits];
  logic [1:0] qa_q, qb_q, qa_d, qb_d;
  logic [1:0] status_q, status_d;
  logic ovalid_q, ovalid_d;
  logic [QW-1:0] n;
  logic wrap;

  always_comb begin
    if (qcount_i == 3'd0) n = QW'(1);
    else if (32'(qcount_i) > MaxQudits) n = QW'(MaxQudits);
    else n = qcount_i[QW-1:0];
  end

  function automatic logic [AddrW:0] pow6(input int unsigned e);
    logic [AddrW:0] r;
    r = (AddrW+1)'(1);
    for (int unsigned t = 0; t < MaxQudits; t++) begin
      if (t < e) r = (AddrW+1)'(r * 3'd6);
    end
    pow6 = r;
  endfunction

  assign dim      = pow6(32'(n));
  assign da       = (32'(qa_q) < MaxQudits) ? dig_q[qa_q] : 3'd0;
  assign db       = (32'(qb_q) < MaxQudits) ? dig_q[qb_q] : 3'd0;

  // Base-6 digit counter that follows i_q.
  always_comb begin
    wrap = 1'b1;
    for (int t = 0; t < MaxQudits; t++) begin
      dig_d[t] = dig_q[t];
      if (wrap) begin
        if (dig_q[t] == 3'd5) dig_d[t] = 3'd0;
        else begin
          dig_d[t] = dig_q[t] + 3'd1;
          wrap = 1'b0;
        end
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;
  assign use_phase_o = (state_q == S_PRD) || (state_q == S_PMAC) || (state_q == S_PWR);
  assign coef_sel_o  = use_phase_o ? mul6(da, db) : mul6(k_q, j_q);
  assign slot_o      = k_q;

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    base_d   = base_q;
    stride_d = stride_q;
    low_d    = low_q;
    k_d      = k_q;
    j_d      = j_q;
    qa_d     = qa_q;
    qb_d     = qb_q;
    status_d = status_q;
    ovalid_d = ovalid_q && !out_ready_i;
    dp_o     = '0;
    addr_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          status_d = ST_DONE;
          qa_d     = qa_i;
          qb_d     = qb_i;
          addr_o   = AddrW'(index_i);
          unique case (cmd_e'(cmd_i))
            CMD_WRITE, CMD_READ: begin
              if (32'(index_i) >= 32'(dim)) begin
                status_d = ST_BAD_INDEX;
                ovalid_d = 1'b1;
                dp_o.res_load = 1'b1;
              end else if (cmd_i == CMD_WRITE) begin
                dp_o.mem_wr   = 1'b1;
                dp_o.res_load = 1'b1;
                ovalid_d      = 1'b1;
              end else begin
                dp_o.mem_rd = 1'b1;
                state_d     = S_RDRES;
              end
            end
            CMD_DFT: begin
              if (QW'(qa_i) >= n || 32'(qa_i) >= MaxQudits) begin
                status_d = ST_BAD_QUDIT;
                ovalid_d = 1'b1;
                dp_o.res_load = 1'b1;
              end else begin
                base_d   = '0;
                low_d    = '0;
                k_d      = '0;
                stride_d = pow6(32'(qa_i));
                state_d  = S_GRD;
              end
            end
            default: begin
              if (QW'(qa_i) >= n || QW'(qb_i) >= n || 32'(qa_i) >= MaxQudits ||
                  32'(qb_i) >= MaxQudits) begin
                status_d = ST_BAD_QUDIT;
                ovalid_d = 1'b1;
                dp_o.res_load = 1'b1;
              end else begin
                i_d     = '0;
                state_d = S_PRD;
              end
            end
          endcase
        end
      end
      S_RDRES: begin
        dp_o.res_load = 1'b1;
        dp_o.res_read = 1'b1;
        ovalid_d      = 1'b1;
        state_d       = S_IDLE;
      end
      S_GRD: begin
        addr_o      = AddrW'(base_q + (AddrW+1)'(k_q) * stride_q);
        dp_o.mem_rd = 1'b1;
        state_d     = S_GLD;
      end
      S_GLD: begin
        dp_o.grp_load = 1'b1;
        if (k_q == 3'd5) begin
          k_d     = '0;
          j_d     = '0;
          dp_o.acc_clr = 1'b1;
          state_d = S_MAC;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_GRD;
        end
      end
      S_MAC: begin
        dp_o.acc_en = 1'b1;
        if (k_q == 3'd5) begin
          k_d     = '0;
          state_d = S_GWR;
        end else k_d = k_q + 3'd1;
      end
      S_GWR: begin
        addr_o        = AddrW'(base_q + (AddrW+1)'(j_q) * stride_q);
        dp_o.mem_wr   = 1'b1;
        dp_o.wr_src   = SRC_ACC;
        dp_o.acc_clr  = 1'b1;
        if (j_q != 3'd5) begin
          j_d     = j_q + 3'd1;
          state_d = S_MAC;
        end else begin
          // Next base whose target digit is zero.
          if (base_q + (AddrW+1)'(1) == dim) begin
            state_d = S_IDLE;
            ovalid_d = 1'b1;
            dp_o.res_load = 1'b1;
          end else begin
            base_d = base_q + (AddrW+1)'(1);
            low_d  = low_q + (AddrW+1)'(1);
            if (low_d == stride_q) begin
              low_d  = '0;
              base_d = base_q + (AddrW+1)'(1) + ((AddrW+1)'(5) * stride_q);
            end
            if (base_d >= dim) begin
              state_d = S_IDLE;
              ovalid_d = 1'b1;
              dp_o.res_load = 1'b1;
            end else state_d = S_GRD;
          end
        end
      end
      S_PRD: begin
        addr_o      = i_q[AddrW-1:0];
        dp_o.mem_rd = 1'b1;
        state_d     = S_PMAC;
      end
      S_PMAC: begin
        dp_o.acc_clr = 1'b1;
        dp_o.acc_en  = 1'b1;
        state_d      = S_PWR;
      end
      default: begin
        addr_o      = i_q[AddrW-1:0];
        dp_o.mem_wr = 1'b1;
        dp_o.wr_src = (coef_sel_o == 3'd0) ? SRC_GROUP : SRC_ACC;
        if (i_q + (AddrW+1)'(1) >= dim) begin
          state_d = S_IDLE;
          ovalid_d = 1'b1;
          dp_o.res_load = 1'b1;
        end else begin
          i_d     = i_q + (AddrW+1)'(1);
          state_d = S_PRD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      status_q <= ST_DONE;
      i_q      <= '0;
      base_q   <= '0;
      stride_q <= '0;
      low_q    <= '0;
      k_q      <= '0;
      j_q      <= '0;
      qa_q     <= '0;
      qb_q     <= '0;
      for (int t = 0; t < MaxQudits; t++) dig_q[t] <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      status_q <= status_d;
      i_q      <= i_d;
      base_q   <= base_d;
      stride_q <= stride_d;
      low_q    <= low_d;
      k_q      <= k_d;
      j_q      <= j_d;
      qa_q     <= qa_d;
      qb_q     <= qb_d;
      if (state_q == S_IDLE) begin
        for (int t = 0; t < MaxQudits; t++) dig_q[t] <= '0;
      end else if (state_q == S_PWR) begin
        for (int t = 0; t < MaxQudits; t++) dig_q[t] <= dig_d[t];
      end
    end
  end

endmodule

>>> rtl/qudit6_gate_engine_unit.sv
// Top level of the base-6 qudit state-vector gate engine.
//   Channel | Direction | Payload
//   s_axis  | in        | tdata: cmd, index, real_in, imag_in, qudit_a, qudit_b
//   m_axis  | out       | tdata: real_out, imag_out, status
//   cfg     | in        | qudit_count
// A write or a failed command is answered from the idle state; a read also passes through the read-result state.
// A DFT works on 6^(n-1) groups of six amplitudes: it loads each group into the
// group registers, then forms and writes back each output in turn, using the single
// memory port and the one shared multiply-accumulate unit.
// A phase gate reads, multiplies and writes back each of the 6^n amplitudes in turn.
// Reset clears control state and sets qudit_count to four; memory is not cleared.
// A stalled result holds the engine until it is taken.
module qudit6_gate_engine_unit #(
  parameter int unsigned MAX_QUDITS = 4,
  parameter int unsigned AMP_WIDTH  = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], index[12:2], real_in[30:13], imag_in[48:31], qudit_a[50:49],
  // qudit_b[52:51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // real_out[17:0], imag_out[35:18], status[37:36]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i
);
  import q6ge_pkg::*;

  localparam int unsigned AddrW = $clog2(6 ** MAX_QUDITS);

  q6ge_pkg::cmd_t dp_cmd;
  logic [2:0] qcount_q, slot, coef_sel;
  logic [AddrW-1:0] addr;
  logic use_phase;
  logic [1:0] status;
  logic signed [IoWidth-1:0] rd_re, rd_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qcount_q <= 3'd4;
    else if (cfg_we_i) qcount_q <= cfg_wdata_i;
  end

  q6ge_controller #(.MaxQudits(MAX_QUDITS), .AddrW(AddrW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tdata[1:0]),
    .index_i    (s_axis_tdata[12:2]),
    .qa_i       (s_axis_tdata[50:49]),
    .qb_i       (s_axis_tdata[52:51]),
    .qcount_i   (qcount_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_o   (status),
    .dp_o       (dp_cmd),
    .addr_o     (addr),
    .slot_o     (slot),
    .coef_sel_o (coef_sel),
    .use_phase_o(use_phase)
  );

  q6ge_datapath #(.MaxQudits(MAX_QUDITS), .AmpWidth(AMP_WIDTH), .AddrW(AddrW)) u_dp (
    .clk_i,
    .cmd_i      (dp_cmd),
    .addr_i     (addr),
    .slot_i     (slot),
    .coef_sel_i (coef_sel),
    .use_phase_i(use_phase),
    .wr_re_i    (s_axis_tdata[30:13]),
    .wr_im_i    (s_axis_tdata[48:31]),
    .rd_re_o    (rd_re),
    .rd_im_o    (rd_im)
  );

  assign m_axis_tdata = {2'b00, status, rd_im, rd_re};

endmodule

>>> rtl/q6ge_checker.sv
// Port-level checker for the gate engine, bound to the top level.
module q6ge_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[37:36] != 2'd3) else $error("bad status");
  a_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[37:36] != 2'd0 |-> m_axis_tdata[35:0] == 36'd0)
    else $error("nonzero data with error");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept twice");
endmodule

bind qudit6_gate_engine_unit q6ge_checker u_chk (.*);
